@@ src/dvfs_frequency_step_governor_top_defines.svh @@
// Assertion macros for the DVFS frequency step governor.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef DVFS_FREQUENCY_STEP_GOVERNOR_TOP_DEFINES_SVH
`define DVFS_FREQUENCY_STEP_GOVERNOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DFSG_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dfsg same-cycle check failed");
// next-cycle implication
`define DFSG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dfsg next-cycle check failed");
`else
`define DFSG_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define DFSG_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ src/dfsg_pkg.sv @@
// Shared types and constants for the DVFS frequency step governor.
// No dependencies.
`default_nettype none
package dfsg_pkg;

   localparam int FREQ_W  = 14;
   localparam int CORE_W  = 6;
   localparam int CNT_W   = 8;
   localparam int CSR_W   = 14;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 2;

   localparam logic [FREQ_W:0]  RISE_LIMIT     = 15'd1000;
   localparam logic [FREQ_W-1:0] MIN_FREQ_RST  = 14'd1000;
   localparam logic [FREQ_W-1:0] MAX_FREQ_RST  = 14'd4000;
   localparam logic [FREQ_W-1:0] FREQ_STEP_RST = 14'd100;
   localparam logic [CNT_W-1:0]  PATIENCE_RST  = 8'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_FREQ     = 2'd0,
      CSR_MAX_FREQ     = 2'd1,
      CSR_FREQ_STEP    = 2'd2,
      CSR_MAX_PATIENCE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [FREQ_W-1:0] min_freq;
      logic [FREQ_W-1:0] max_freq;
      logic [FREQ_W-1:0] freq_step;
      logic [CNT_W-1:0]  max_patience;
   } cfg_type;

   typedef struct packed {
      logic [CORE_W-1:0] core_index;
      logic [FREQ_W-1:0] current_frequency;
      logic [FREQ_W-1:0] requested_frequency;
   } item_type;

   typedef struct packed {
      logic [CNT_W-1:0] down_used;
      logic [CNT_W-1:0] up_used;
   } cnt_pair_type;

   typedef struct packed {
      logic [CORE_W-1:0] core_out;
      logic [FREQ_W-1:0] granted_frequency;
      logic              apply_change;
      logic              held_back;
   } result_type;

endpackage
`default_nettype wire

@@ src/dfsg_cnt_store.sv @@
// Per-core delay counter store: memory with registered read, reset valid bits
// and write-to-read bypass. Depends on dfsg_pkg.
`default_nettype none
module dfsg_cnt_store #(
   parameter int CORES = 64,
   parameter int IDX_W = 6
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  rd_en,
   input  wire logic [IDX_W-1:0]      rd_addr,
   output dfsg_pkg::cnt_pair_type     rd_data,
   input  wire logic                  wr_en,
   input  wire logic [IDX_W-1:0]      wr_addr,
   input  dfsg_pkg::cnt_pair_type     wr_data
);

   dfsg_pkg::cnt_pair_type mem [CORES];
   logic [CORES-1:0]       valid_ff;
   dfsg_pkg::cnt_pair_type mem_rd_ff;
   dfsg_pkg::cnt_pair_type byp_data_ff;
   logic                   byp_ff;
   logic                   byp_in;
   logic                   hit_ff;
   logic                   hit_in;

   assign byp_in = wr_en && (wr_addr == rd_addr);
   assign hit_in = valid_ff[rd_addr];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_rd_ff   <= mem[rd_addr];
         byp_data_ff <= wr_data;
         byp_ff      <= byp_in;
         hit_ff      <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : (hit_ff ? mem_rd_ff : '0);

endmodule
`default_nettype wire

@@ src/dfsg_decide.sv @@
// Clamp and hysteresis decision for one request.
// Depends on dfsg_pkg.
`default_nettype none
module dfsg_decide (
   input  dfsg_pkg::cfg_type      cfg,
   input  dfsg_pkg::item_type     item,
   input  wire logic              in_range,
   input  dfsg_pkg::cnt_pair_type cnt,
   output dfsg_pkg::cnt_pair_type cnt_next,
   output dfsg_pkg::result_type   result
);

   logic [dfsg_pkg::FREQ_W:0]   cap;
   logic [dfsg_pkg::FREQ_W-1:0] cur;
   logic [dfsg_pkg::FREQ_W-1:0] f_cap;
   logic [dfsg_pkg::FREQ_W-1:0] f_min;
   logic [dfsg_pkg::FREQ_W-1:0] f_lim;
   logic                        is_down;
   logic                        is_up;
   logic                        down_ok;
   logic                        up_ok;
   logic                        held;

   always_comb begin
      cur   = item.current_frequency;
      cap   = {1'b0, cur} + dfsg_pkg::RISE_LIMIT;
      f_cap = ({1'b0, item.requested_frequency} > cap) ?
              cap[dfsg_pkg::FREQ_W-1:0] : item.requested_frequency;
      f_min = (f_cap < cfg.min_freq) ? cfg.min_freq : f_cap;
      f_lim = (f_min > cfg.max_freq) ? cfg.max_freq : f_min;

      is_down = (({1'b0, f_lim} + {1'b0, cfg.freq_step}) == {1'b0, cur});
      is_up   = (({1'b0, cur} + {1'b0, cfg.freq_step}) == {1'b0, f_lim});

      // down direction wins when a zero step matches both
      down_ok = in_range && is_down && (cnt.down_used < cfg.max_patience);
      up_ok   = in_range && is_up && (cnt.up_used < cfg.max_patience) && !down_ok;
      held    = down_ok || up_ok;

      cnt_next = '0;
      if (down_ok) begin
         cnt_next.down_used = cnt.down_used + 8'd1;
         cnt_next.up_used   = cnt.up_used;
      end else if (up_ok) begin
         cnt_next.down_used = cnt.down_used;
         cnt_next.up_used   = cnt.up_used + 8'd1;
      end

      result.core_out          = item.core_index;
      result.granted_frequency = held ? cur : f_lim;
      result.apply_change      = !held && (f_lim != cur);
      result.held_back         = held;
   end

endmodule
`default_nettype wire

@@ src/dvfs_frequency_step_governor_top.sv @@
// Top level of the DVFS frequency step governor: CSRs, input stage, result
// register. Depends on dfsg_pkg, dfsg_cnt_store, dfsg_decide and the defines header.
//
//   channel | dir | handshake        | contents
//   req     | in  | tvalid / tready  | tdata: core_index, current_frequency, requested_frequency
//   rsp     | out | tvalid / tready  | tdata: core_out, granted_frequency; tuser: flags
//   csr     | in  | csr_we (no wait) | index 0..3, write data
//
// One transaction per cycle sustained while rsp is not stalled; the input stage and counter read
// register load at req acceptance, then the result register loads and rsp_tvalid rises.
// Synchronous reset restores CSR defaults and clears every counter valid bit at once.
// A stalled rsp holds the input stage; req_tready follows whether that stage can move.
`default_nettype none
`include "dvfs_frequency_step_governor_top_defines.svh"
module dvfs_frequency_step_governor_top #(
   parameter int CORES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [5:0] core_index, [19:6] current_frequency, [33:20] requested_frequency, [39:34] zero
   input  wire logic [dfsg_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [5:0] core_out, [19:6] granted_frequency, [23:20] zero
   output logic [dfsg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] apply_change, [1] held_back
   output logic [dfsg_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic [dfsg_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [dfsg_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int IDX_W = (CORES > 1) ? $clog2(CORES) : 1;

   dfsg_pkg::cfg_type      cfg_ff;
   dfsg_pkg::cfg_type      cfg_in;
   dfsg_pkg::item_type     req_item;
   dfsg_pkg::item_type     s1_item_ff;
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic                   s1_fire;
   logic                   s1_in_range;
   logic                   req_accept;
   dfsg_pkg::cnt_pair_type cnt_rd;
   dfsg_pkg::cnt_pair_type cnt_wr;
   dfsg_pkg::result_type   result;
   dfsg_pkg::result_type   rsp_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (dfsg_pkg::csr_index_type'(csr_index))
            dfsg_pkg::CSR_MIN_FREQ:     cfg_in.min_freq     = csr_wdata;
            dfsg_pkg::CSR_MAX_FREQ:     cfg_in.max_freq     = csr_wdata;
            dfsg_pkg::CSR_FREQ_STEP:    cfg_in.freq_step    = csr_wdata;
            dfsg_pkg::CSR_MAX_PATIENCE: cfg_in.max_patience = csr_wdata[dfsg_pkg::CNT_W-1:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_freq     <= dfsg_pkg::MIN_FREQ_RST;
         cfg_ff.max_freq     <= dfsg_pkg::MAX_FREQ_RST;
         cfg_ff.freq_step    <= dfsg_pkg::FREQ_STEP_RST;
         cfg_ff.max_patience <= dfsg_pkg::PATIENCE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_item.core_index          = req_tdata[5:0];
   assign req_item.current_frequency   = req_tdata[19:6];
   assign req_item.requested_frequency = req_tdata[33:20];

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_accept = req_tvalid && req_tready;
   assign s1_in_range = ({3'b000, s1_item_ff.core_index} < 9'(CORES));

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   dfsg_cnt_store #(
      .CORES (CORES),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (IDX_W'(req_item.core_index)),
      .rd_data (cnt_rd),
      .wr_en   (s1_fire && s1_in_range),
      .wr_addr (IDX_W'(s1_item_ff.core_index)),
      .wr_data (cnt_wr)
   );

   dfsg_decide u_decide (
      .cfg      (cfg_ff),
      .item     (s1_item_ff),
      .in_range (s1_in_range),
      .cnt      (cnt_rd),
      .cnt_next (cnt_wr),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_item;
      end
      if (s1_fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_ff.granted_frequency, rsp_ff.core_out};
   assign rsp_tuser  = {rsp_ff.held_back, rsp_ff.apply_change};

   `DFSG_ASSERT_NEXT(a_accept_loads_stage, clock, reset, req_accept, s1_valid_ff)
   `DFSG_ASSERT_NEXT(a_stage_holds, clock, reset, s1_valid_ff && !s1_fire, s1_valid_ff)
   `DFSG_ASSERT_SAME(a_ready_low_busy, clock, reset, !req_tready, s1_valid_ff && rsp_valid_ff)
   `DFSG_ASSERT_SAME(a_held_no_apply, clock, reset, rsp_tvalid && rsp_tuser[1], !rsp_tuser[0])
   `DFSG_ASSERT_NEXT(a_fire_gives_rsp, clock, reset, s1_fire, rsp_tvalid)

endmodule
`default_nettype wire
